/* design/srx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared codes, constants and the result word type.
// ----------------------------------------------------------------------------
package srx_pkg;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD     = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [7:0] HDR_FIRST  = 8'h4D;
  localparam logic [7:0] HDR_SECOND = 8'h58;
  localparam logic [7:0] GAP_RESET  = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_HDR2    = 3'd2,
    PH_TYPE    = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic       byte_valid;
    logic       frame_end;
    logic [1:0] frame_status;
  } srx_result_t;

endpackage

/* design/srx_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver core
// Frame state machine, checksum, wait budget and result decode per word.
// ----------------------------------------------------------------------------
module srx_core import srx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  first_wait,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic        result_valid,
  output srx_result_t result
);

  phase_t     phase, phase_next;
  logic [7:0] byte_gap_ticks;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] wait_timer, wait_timer_next;
  logic [8:0] position, position_next;
  logic [7:0] timer_dec;
  logic [7:0] count_inc;
  logic       hdr_match;

  assign timer_dec = (wait_timer == 8'd0) ? 8'd0 : wait_timer - 8'd1;
  assign count_inc = payload_count + 8'd1;
  assign hdr_match = (phase == PH_HDR1) ? (rx_byte == HDR_FIRST) : (rx_byte == HDR_SECOND);

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    wait_timer_next     = wait_timer;
    position_next       = position;
    if (item_valid) begin
      case (mode)
        MODE_START: begin
          running_sum_next    = 8'd0;
          payload_length_next = 8'd0;
          payload_count_next  = 8'd0;
          position_next       = 9'd0;
          wait_timer_next     = first_wait;
          phase_next          = (first_wait == 8'd0) ? PH_IDLE : PH_HDR1;
        end
        MODE_TICK: begin
          if (phase != PH_IDLE) begin
            wait_timer_next = timer_dec;
            if (timer_dec == 8'd0) begin
              phase_next = PH_IDLE;
            end
          end
        end
        MODE_BYTE: begin
          if (phase != PH_IDLE && phase != PH_CHECK &&
              !((phase == PH_HDR1 || phase == PH_HDR2) && !hdr_match)) begin
            running_sum_next = running_sum + rx_byte;
            position_next    = position + 9'd1;
            wait_timer_next  = byte_gap_ticks;
          end
          case (phase)
            PH_HDR1: begin
              phase_next = hdr_match ? PH_HDR2 : PH_IDLE;
            end
            PH_HDR2: begin
              phase_next = hdr_match ? PH_TYPE : PH_IDLE;
            end
            PH_TYPE: begin
              phase_next = PH_LEN;
            end
            PH_LEN: begin
              payload_length_next = rx_byte;
              payload_count_next  = 8'd0;
              phase_next          = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              payload_count_next = count_inc;
              if (count_inc == payload_length) begin
                phase_next = PH_CHECK;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_valid        = 1'b0;
    result.data_byte    = 8'd0;
    result.byte_index   = 9'd0;
    result.byte_valid   = 1'b0;
    result.frame_end    = 1'b0;
    result.frame_status = STATUS_OK;
    if (item_valid) begin
      case (mode)
        MODE_START: begin
          if (first_wait == 8'd0) begin
            result_valid        = 1'b1;
            result.frame_end    = 1'b1;
            result.frame_status = STATUS_TIMEOUT;
          end
        end
        MODE_TICK: begin
          if (phase != PH_IDLE && timer_dec == 8'd0) begin
            result_valid        = 1'b1;
            result.frame_end    = 1'b1;
            result.frame_status = STATUS_TIMEOUT;
          end
        end
        MODE_BYTE: begin
          case (phase)
            PH_HDR1, PH_HDR2: begin
              result_valid = 1'b1;
              if (hdr_match) begin
                result.data_byte  = rx_byte;
                result.byte_index = position;
                result.byte_valid = 1'b1;
              end else begin
                result.frame_end    = 1'b1;
                result.frame_status = STATUS_BAD;
              end
            end
            PH_TYPE, PH_LEN, PH_PAYLOAD: begin
              result_valid      = 1'b1;
              result.data_byte  = rx_byte;
              result.byte_index = position;
              result.byte_valid = 1'b1;
            end
            PH_CHECK: begin
              result_valid        = 1'b1;
              result.data_byte    = rx_byte;
              result.byte_index   = position;
              result.byte_valid   = 1'b1;
              result.frame_end    = 1'b1;
              result.frame_status = (rx_byte == running_sum) ? STATUS_OK : STATUS_BAD;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_gap_ticks <= GAP_RESET;
      running_sum    <= 8'd0;
      payload_length <= 8'd0;
      payload_count  <= 8'd0;
      wait_timer     <= 8'd0;
      position       <= 9'd0;
    end else begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      wait_timer     <= wait_timer_next;
      position       <= position_next;
      if (cfg_wr_en) begin
        byte_gap_ticks <= cfg_wr_data;
      end
    end
  end

endmodule

/* design/srx_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver output buffer
// Two-entry output register with skid entry; ready is high while a slot is free.
// ----------------------------------------------------------------------------
module srx_out_buf import srx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  srx_result_t push_data,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output srx_result_t out_data
);

  srx_result_t entry0, entry1;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = entry0;
  assign space     = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (pop) begin
      entry0 <= (count == 2'd2) ? entry1 : push_data;
      entry1 <= push_data;
    end else if (push) begin
      if (count == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count - {1'b0, pop} + {1'b0, push};
    end
  end

endmodule

/* design/serial_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame receiver
// A result word is registered in the output buffer before it appears on the master side.
// Throughput: one input word per cycle while the output buffer has a free slot.
// A two-entry output buffer keeps input flowing while a result waits to be taken.
// Reset: frame state idle, counters cleared, byte gap register 2, output buffer empty.
// ----------------------------------------------------------------------------
module serial_frame_receiver import srx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte [7:0], first_wait [15:8]
  input  logic [1:0]  s_axis_tuser,  // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // data_byte [7:0], byte_index [16:8], zero [23:17]
  output logic [2:0]  m_axis_tuser,  // byte_valid [0], frame_status [2:1]
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic        accept;
  logic        result_valid;
  srx_result_t result;
  srx_result_t out_word;

  assign accept = s_axis_tvalid && s_axis_tready;

  srx_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (accept),
    .mode         (s_axis_tuser),
    .rx_byte      (s_axis_tdata[7:0]),
    .first_wait   (s_axis_tdata[15:8]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result       (result)
  );

  srx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .space     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_word)
  );

  assign m_axis_tdata = {7'd0, out_word.byte_index, out_word.data_byte};
  assign m_axis_tuser = {out_word.frame_status, out_word.byte_valid};
  assign m_axis_tlast = out_word.frame_end;

endmodule
